FILE: rtl/blcde_pkg.sv
// Package: shared types and constants for the box-line cell drawing engine.
`default_nettype none
package blcde_pkg;
   localparam logic [2:0] ACT_HLINE = 3'd0;
   localparam logic [2:0] ACT_VLINE = 3'd1;
   localparam logic [2:0] ACT_BOX   = 3'd2;
   localparam logic [2:0] ACT_CLRIN = 3'd3;
   localparam logic [2:0] ACT_CLRALL= 3'd4;
   localparam logic [2:0] ACT_READ  = 3'd5;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;

   // Per-cell edit: keep mask and bits to OR in.
   typedef struct packed {
      logic [7:0] keep;
      logic [7:0] bits;
   } edit_type;

   function automatic logic [7:0] edge_top(input logic [1:0] x);
      return {x, 6'd0};
   endfunction
   function automatic logic [7:0] edge_left(input logic [1:0] x);
      return {2'd0, x, 4'd0};
   endfunction
   function automatic logic [7:0] edge_bottom(input logic [1:0] x);
      return {4'd0, x, 2'd0};
   endfunction
   function automatic logic [7:0] edge_right(input logic [1:0] x);
      return {6'd0, x};
   endfunction
endpackage
`default_nettype wire

FILE: rtl/blcde_if.sv
// Interfaces: request, response and register write channels.
`default_nettype none
interface blcde_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [1:0] line_type;
   logic [5:0] row_a;
   logic [6:0] col_a;
   logic [5:0] row_b;
   logic [6:0] col_b;
   modport source (output valid, action, line_type, row_a, col_a, row_b, col_b, input ready);
   modport sink   (input valid, action, line_type, row_a, col_a, row_b, col_b, output ready);
endinterface

interface blcde_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] cell_value;
   modport source (output valid, status, cell_value, input ready);
   modport sink   (input valid, status, cell_value, output ready);
endinterface

interface blcde_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/blcde_mem.sv
// Cell store: one read and one write port, registered read data.
`default_nettype none
module blcde_mem #(
   parameter int ADDR_W = 13
) (
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data
);
   logic [7:0] mem_ff [0:(1<<ADDR_W)-1];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/box_line_cell_drawing_engine_unit.sv
// Top level: command sequencer walking the cell store with read-modify-write.
// Box-line cell drawing engine. Each command is one request word and gives one
// response word. The cells sit in a single synchronous RAM with one read port,
// one write port and registered read data. Every cell edit is a
// read-modify-write: read issue, then modify and write back. No two accesses
// to the same cell overlap, so no forwarding is needed.
// Walks by command:
//   line       every cell from end to end, span+1 cells
//   box        its two columns, then its two rows, in turn
//   clear-inside  every cell of the rectangle
// Responses:
//   A walk puts its response word out after its last cell is written back, and
//   the next request is taken only once the response state is left.
//   A read goes through address issue, data capture and the response state.
//   A range error, an unused action or an empty clear-inside goes straight to
//   the response state.
//   Clear all and the clearing pass after reset write every one of
//   2^(RW+CW) cells, one a cycle. That is 8192 cells at the defaults.
//   Requests are held off during the pass. A clear-all goes to the response
//   state after its pass; the pass after reset gives no response.
// A response word that is not taken parks the sequencer in its response state
// once the next command's work is done. The request side then stalls.
// Register writes are taken at any time and belong between commands.
`default_nettype none
module box_line_cell_drawing_engine_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 128
) (
   input  wire logic   clock,
   input  wire logic   reset,
   blcde_req_if.sink   req,
   blcde_rsp_if.source rsp,
   blcde_csr_if.sink   csr
);
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW = RW + CW;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1; // read issued, next cycle modify
   localparam logic [2:0] ST_WR    = 3'd2; // modify and write
   localparam logic [2:0] ST_SWEEP = 3'd3; // clear everything
   localparam logic [2:0] ST_READ  = 3'd4; // read-cell address issued
   localparam logic [2:0] ST_RDCAP = 3'd5; // read-cell data captured
   localparam logic [2:0] ST_RESP  = 3'd6;

   // walk kinds
   localparam logic [1:0] WK_H = 2'd0;   // along a row
   localparam logic [1:0] WK_V = 2'd1;   // down a column
   localparam logic [1:0] WK_C = 2'd2;   // clear-inside, row by row

   logic [2:0]    state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic          box_ff, box_in;
   logic [1:0]    part_ff, part_in;     // box side being walked
   logic [1:0]    typ_ff, typ_in;
   logic [5:0]    row_ff, row_in, rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [5:0]    ra_ff, ra_in, rb_ff, rb_in;
   logic [6:0]    col_ff, col_in, clo_ff, clo_in, chi_ff, chi_in, cb_ff, cb_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          silent_ff, silent_in;  // pass after reset: no response
   logic          jst_ff, jst_in;
   logic [7:0]    jval_ff, jval_in;
   logic          rsp_v_ff, rsp_v_in, rsp_st_ff, rsp_st_in;
   logic [7:0]    rsp_val_ff, rsp_val_in;
   logic [6:0]    rows_ff;
   logic [7:0]    cols_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    rd_data, wr_data;
   logic          wr_en;
   blcde_pkg::edit_type ed;

   // configuration
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 7'd64;
         cols_ff <= 8'd128;
      end else if (csr.valid) begin
         if (csr.index == blcde_pkg::REG_ROWS) rows_ff <= csr.data[6:0];
         else if (csr.index == blcde_pkg::REG_COLS) cols_ff <= csr.data;
      end
   end

   // effective counts, capped
   logic [10:0] nr, nc;
   assign nr = ({4'd0, rows_ff} > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : {4'd0, rows_ff};
   assign nc = ({3'd0, cols_ff} > 11'(MAX_COLS)) ? 11'(MAX_COLS) : {3'd0, cols_ff};

   logic [5:0] rmin, rmax;
   logic [6:0] cmin, cmax;
   assign rmax = (req.row_a > req.row_b) ? req.row_a : req.row_b;
   assign rmin = (req.row_a > req.row_b) ? req.row_b : req.row_a;
   assign cmax = (req.col_a > req.col_b) ? req.col_a : req.col_b;
   assign cmin = (req.col_a > req.col_b) ? req.col_b : req.col_a;
   logic ra_ok, ca_ok, rm_ok, cm_ok;
   assign ra_ok = {5'd0, req.row_a} < nr;
   assign ca_ok = {4'd0, req.col_a} < nc;
   assign rm_ok = {5'd0, rmax} < nr;
   assign cm_ok = {4'd0, cmax} < nc;

   assign req.ready = (state_ff == ST_IDLE);

   assign rd_addr = {RW'(row_ff), CW'(col_ff)};

   // where the current cell sits in its walk
   logic c_gt, c_lt, r_gt, r_lt, c_mid;
   assign c_gt  = col_ff > clo_ff;
   assign c_lt  = col_ff < chi_ff;
   assign r_gt  = row_ff > rlo_ff;
   assign r_lt  = row_ff < rhi_ff;
   assign c_mid = c_gt && c_lt;

   // edit for current cell: a line sets the fields facing its neighbors on
   // the walk, a clear-inside wipes the fields facing the inside
   always_comb begin
      ed.keep = 8'hFF;
      ed.bits = 8'h00;
      case (mode_ff)
         WK_H: begin
            if (c_gt) begin
               ed.keep = ed.keep & ~blcde_pkg::edge_left(2'd3);
               ed.bits = ed.bits | blcde_pkg::edge_left(typ_ff);
            end
            if (c_lt) begin
               ed.keep = ed.keep & ~blcde_pkg::edge_right(2'd3);
               ed.bits = ed.bits | blcde_pkg::edge_right(typ_ff);
            end
         end
         WK_V: begin
            if (r_gt) begin
               ed.keep = ed.keep & ~blcde_pkg::edge_top(2'd3);
               ed.bits = ed.bits | blcde_pkg::edge_top(typ_ff);
            end
            if (r_lt) begin
               ed.keep = ed.keep & ~blcde_pkg::edge_bottom(2'd3);
               ed.bits = ed.bits | blcde_pkg::edge_bottom(typ_ff);
            end
         end
         WK_C: begin
            if (!r_gt) begin
               if (c_mid) ed.keep = ~blcde_pkg::edge_bottom(2'd3);
            end else if (!r_lt) begin
               if (c_mid) ed.keep = ~blcde_pkg::edge_top(2'd3);
            end else if (!c_gt) begin
               ed.keep = ~blcde_pkg::edge_right(2'd3);
            end else if (!c_lt) begin
               ed.keep = ~blcde_pkg::edge_left(2'd3);
            end else begin
               ed.keep = 8'h00;
            end
         end
         default: ed.keep = 8'hFF;
      endcase
   end

   // last cell of the current walk
   logic walk_end;
   always_comb begin
      case (mode_ff)
         WK_H:    walk_end = (col_ff == chi_ff);
         WK_V:    walk_end = (row_ff == rhi_ff);
         default: walk_end = (row_ff == rhi_ff) && (col_ff == chi_ff);
      endcase
   end

   always_comb begin
      state_in  = state_ff;  mode_in  = mode_ff;  box_in = box_ff;  part_in = part_ff;
      typ_in    = typ_ff;    row_in   = row_ff;   col_in = col_ff;
      rlo_in    = rlo_ff;    rhi_in   = rhi_ff;   clo_in = clo_ff;  chi_in  = chi_ff;
      ra_in     = ra_ff;     rb_in    = rb_ff;    cb_in  = cb_ff;
      sweep_in  = sweep_ff;  silent_in = silent_ff;
      jst_in    = jst_ff;    jval_in  = jval_ff;
      rsp_v_in  = rsp_v_ff && !rsp.ready;
      rsp_st_in = rsp_st_ff; rsp_val_in = rsp_val_ff;
      wr_en = 1'b0; wr_addr = rd_addr;
      wr_data = (rd_data & ed.keep) | ed.bits;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               typ_in = req.line_type;
               rlo_in = rmin; rhi_in = rmax; clo_in = cmin; chi_in = cmax;
               ra_in = req.row_a; rb_in = req.row_b; cb_in = req.col_b;
               box_in = 1'b0; part_in = 2'd0;
               jst_in = 1'b0; jval_in = 8'h00;
               state_in = ST_RESP;
               case (req.action)
                  blcde_pkg::ACT_HLINE: begin
                     jst_in = !(ra_ok && cm_ok);
                     if (ra_ok && cm_ok) begin
                        state_in = ST_RD; mode_in = WK_H;
                        row_in = req.row_a; col_in = cmin;
                     end
                  end
                  blcde_pkg::ACT_VLINE: begin
                     jst_in = !(rm_ok && ca_ok);
                     if (rm_ok && ca_ok) begin
                        state_in = ST_RD; mode_in = WK_V;
                        row_in = rmin; col_in = req.col_a;
                     end
                  end
                  blcde_pkg::ACT_BOX: begin
                     jst_in = !(rm_ok && cm_ok);
                     if (rm_ok && cm_ok) begin
                        // sides in turn: column a, column b, row a, row b
                        state_in = ST_RD; mode_in = WK_V; box_in = 1'b1;
                        row_in = rmin; col_in = req.col_a;
                     end
                  end
                  blcde_pkg::ACT_CLRIN: begin
                     jst_in = !(rm_ok && cm_ok);
                     // equal rows or columns: nothing inside
                     if (rm_ok && cm_ok && (rmin != rmax) && (cmin != cmax)) begin
                        state_in = ST_RD; mode_in = WK_C;
                        row_in = rmin; col_in = cmin;
                     end
                  end
                  blcde_pkg::ACT_CLRALL: begin
                     state_in = ST_SWEEP; sweep_in = '0; silent_in = 1'b0;
                  end
                  blcde_pkg::ACT_READ: begin
                     jst_in = !(ra_ok && ca_ok);
                     if (ra_ok && ca_ok) begin
                        state_in = ST_READ; row_in = req.row_a; col_in = req.col_a;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RD: state_in = ST_WR;
         ST_WR: begin
            wr_en = 1'b1;
            state_in = ST_RD;
            if (!walk_end) begin
               case (mode_ff)
                  WK_H: col_in = col_ff + 7'd1;
                  WK_V: row_in = row_ff + 6'd1;
                  default: begin
                     if (col_ff == chi_ff) begin
                        col_in = clo_ff; row_in = row_ff + 6'd1;
                     end else col_in = col_ff + 7'd1;
                  end
               endcase
            end else if (box_ff && (part_ff != 2'd3)) begin
               part_in = part_ff + 2'd1;
               case (part_ff)
                  2'd0: begin mode_in = WK_V; row_in = rlo_ff; col_in = cb_ff;  end
                  2'd1: begin mode_in = WK_H; row_in = ra_ff;  col_in = clo_ff; end
                  default: begin mode_in = WK_H; row_in = rb_ff; col_in = clo_ff; end
               endcase
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SWEEP: begin
            wr_en = 1'b1; wr_data = 8'h00; wr_addr = sweep_ff;
            sweep_in = sweep_ff + AW'(1);
            if (&sweep_ff) begin
               state_in  = silent_ff ? ST_IDLE : ST_RESP;
               silent_in = 1'b0;
            end
         end
         ST_READ: state_in = ST_RDCAP;
         ST_RDCAP: begin
            jval_in  = rd_data;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // output register free or emptying this cycle
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in = 1'b1; rsp_st_in = jst_ff; rsp_val_in = jval_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         sweep_ff   <= '0;
         silent_ff  <= 1'b1;
         mode_ff    <= WK_H;
         box_ff     <= 1'b0;
         part_ff    <= 2'd0;
         typ_ff     <= 2'd0;
         row_ff     <= 6'd0;
         col_ff     <= 7'd0;
         rlo_ff     <= 6'd0;
         rhi_ff     <= 6'd0;
         clo_ff     <= 7'd0;
         chi_ff     <= 7'd0;
         ra_ff      <= 6'd0;
         rb_ff      <= 6'd0;
         cb_ff      <= 7'd0;
         jst_ff     <= 1'b0;
         jval_ff    <= 8'h00;
         rsp_v_ff   <= 1'b0;
         rsp_st_ff  <= 1'b0;
         rsp_val_ff <= 8'h00;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         silent_ff  <= silent_in;
         mode_ff    <= mode_in;
         box_ff     <= box_in;
         part_ff    <= part_in;
         typ_ff     <= typ_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         rlo_ff     <= rlo_in;
         rhi_ff     <= rhi_in;
         clo_ff     <= clo_in;
         chi_ff     <= chi_in;
         ra_ff      <= ra_in;
         rb_ff      <= rb_in;
         cb_ff      <= cb_in;
         jst_ff     <= jst_in;
         jval_ff    <= jval_in;
         rsp_v_ff   <= rsp_v_in;
         rsp_st_ff  <= rsp_st_in;
         rsp_val_ff <= rsp_val_in;
      end
   end

   blcde_mem #(.ADDR_W(AW)) u_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign rsp.valid      = rsp_v_ff;
   assign rsp.status     = rsp_st_ff;
   assign rsp.cell_value = rsp_val_ff;
endmodule
`default_nettype wire
